>>> src/mlcd_pkg.sv
// Shared types, constants and helper functions for the multiplexed LCD segment driver.
package mlcd_pkg;

  // Field widths of one input item and one result item.
  localparam int FuncW   = 3;
  localparam int DigitW  = 8;
  localparam int NumW    = 16;
  localparam int ModeW   = 2;
  localparam int ComW    = 3;
  localparam int SegW    = 12;
  localparam int NumDig  = 4;
  localparam int CfgW    = 8;
  localparam int InDataW  = 56;
  localparam int OutDataW = 16;
  localparam logic [CfgW-1:0] ScanIntervalRst = 8'd5;

  // Reciprocal constants for division by powers of ten.
  localparam logic [16:0] RecipTenK  = 17'd107375;  // shift 30, valid below 65536
  localparam logic [14:0] RecipThou  = 15'd16778;   // shift 24, valid below 10000
  localparam logic [13:0] RecipHund  = 14'd10486;   // shift 20, valid below 10000
  localparam logic [13:0] RecipTen   = 14'd13108;   // shift 17, valid below 10000
  localparam logic [13:0] TenK       = 14'd10000;

  // Command codes carried in tuser.
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK    = 3'd0,
    FUNC_LOAD    = 3'd1,
    FUNC_NUMBER  = 3'd2,
    FUNC_BATTERY = 3'd3,
    FUNC_PLAY    = 3'd4,
    FUNC_COLON   = 3'd5,
    FUNC_CLEAR   = 3'd6
  } func_e;

  // Icon modes for the play mark and the colon.
  localparam logic [ModeW-1:0] IconOff = 2'd0;
  localparam logic [ModeW-1:0] IconOn  = 2'd1;

  // Decimal digits, most significant first.
  typedef struct packed {
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } bcd_t;

  typedef logic [NumDig-1:0][DigitW-1:0] digits_t;
  typedef logic [2:0][SegW-1:0] rows_t;

  // Seven-segment font, hex capable.
  function automatic logic [DigitW-1:0] mlcd_font(input logic [3:0] val);
    logic [DigitW-1:0] seg;
    case (val)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h67;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h58;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      default: seg = 8'h71;
    endcase
    return seg;
  endfunction

  // Remap the digit bytes onto the three COM row patterns.
  function automatic rows_t mlcd_rows(input digits_t dig);
    rows_t r;
    r = '0;
    for (int i = 0; i < NumDig; i++) begin
      r[0][3*i+1] = dig[i][0];
      r[0][3*i+2] = dig[i][1];
      r[1][3*i+2] = dig[i][2];
      r[2][3*i+1] = dig[i][3];
      r[1][3*i]   = dig[i][4];
      r[0][3*i]   = dig[i][5];
      r[1][3*i+1] = dig[i][6];
    end
    // Icons: play, battery ends, battery middle, colon.
    r[2][9] = dig[0][7];
    r[2][0] = dig[1][7];
    r[2][2] = dig[2][7];
    r[2][5] = dig[3][7];
    return r;
  endfunction

endpackage

>>> src/mlcd_bcd.sv
// Two-stage binary to decimal converter for the number command.
module mlcd_bcd (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [mlcd_pkg::NumW-1:0] number_i,
  output mlcd_pkg::bcd_t           digits_o
);
  import mlcd_pkg::*;

  logic [32:0] prod_tenk;
  logic [NumW-1:0] num_a_q;
  logic [2:0]      q4_a_q;
  logic [NumW-1:0] rem_full;
  logic [13:0]     rem;
  logic [28:0]     prod_thou;
  logic [27:0]     prod_hund;
  logic [27:0]     prod_ten;
  logic [13:0]     rem_b_q;
  logic [3:0]      q1000_b_q;
  logic [6:0]      q100_b_q;
  logic [9:0]      q10_b_q;
  logic [6:0]      d2_full;
  logic [9:0]      d1_full;
  logic [13:0]     d0_full;

  // Stage A: quotient by ten thousand through the reciprocal.
  assign prod_tenk = 33'(number_i) * 33'(RecipTenK);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_a_q <= number_i;
      q4_a_q  <= prod_tenk[32:30];
    end
  end

  // Stage B: remainder below ten thousand, then its quotients by 1000, 100 and 10.
  assign rem_full  = num_a_q - 16'(17'(q4_a_q) * 17'(TenK));
  assign rem       = rem_full[13:0];
  assign prod_thou = 29'(rem) * 29'(RecipThou);
  assign prod_hund = 28'(rem) * 28'(RecipHund);
  assign prod_ten  = 28'(rem) * 28'(RecipTen);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_b_q   <= rem;
      q1000_b_q <= prod_thou[27:24];
      q100_b_q  <= prod_hund[26:20];
      q10_b_q   <= prod_ten[26:17];
    end
  end

  // Each digit is a quotient less ten times the next coarser quotient.
  assign d2_full = q100_b_q - 7'(q1000_b_q * 7'd10);
  assign d1_full = q10_b_q - 10'(q100_b_q * 10'd10);
  assign d0_full = rem_b_q - 14'(q10_b_q * 14'd10);

  assign digits_o.d3 = q1000_b_q;
  assign digits_o.d2 = d2_full[3:0];
  assign digits_o.d1 = d1_full[3:0];
  assign digits_o.d0 = d0_full[3:0];

endmodule

>>> src/multiplexed_lcd_segment_driver_top.sv
// Top level of the multiplexed LCD segment driver: command pipeline, scan state and output stage.
// Each item passes the input register, two decimal conversion stages and the output register.
// Throughput: one item per cycle while the skid register is empty; the three-stage pipeline
// and a one-entry skid register keep tready high while one result waits in the output register.
// Reset (asynchronous, active low) clears digits, rows and tick count, sets first half,
// releases all COM lines to high impedance and drives every SEG high; scan interval is 5.
module multiplexed_lcd_segment_driver_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mlcd_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // digit_zero[7:0], digit_one[15:8], digit_two[23:16], digit_three[31:24],
  // number[47:32], mode[49:48], zero fill[55:50]
  input  logic [mlcd_pkg::InDataW-1:0] s_axis_tdata,
  // func[2:0]
  input  logic [mlcd_pkg::FuncW-1:0]   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // com_enable[2:0], com_level[3], seg_levels[15:4]
  output logic [mlcd_pkg::OutDataW-1:0] m_axis_tdata
);
  import mlcd_pkg::*;

  typedef struct packed {
    func_e      func;
    digits_t    digits;
    logic [ModeW-1:0] mode;
  } item_t;

  logic                 adv;
  logic                 s_fire;
  logic                 res_fire;
  logic                 m_fire;
  logic [CfgW-1:0]      scan_interval_q;
  logic                 s1_valid_q, s2_valid_q, s3_valid_q;
  item_t                s1_item_q, s2_item_q, s3_item_q;
  item_t                in_item;
  logic [NumW-1:0]      s1_number_q;
  bcd_t                 bcd;
  digits_t              digit_q, digit_d;
  rows_t                rows_q;
  logic [CfgW-1:0]      tick_q, tick_d;
  logic [1:0]           com_q, com_d;
  logic                 first_q, first_d;
  logic [ComW-1:0]      com_en_q, com_en_d;
  logic                 com_lvl_q, com_lvl_d;
  logic [SegW-1:0]      seg_q, seg_d;
  logic                 step;
  logic [1:0]           cur;
  logic [SegW-1:0]      row;
  logic [OutDataW-1:0]  result;
  logic                 out_valid_q, skid_valid_q;
  logic [OutDataW-1:0]  out_q, skid_q;

  // The whole pipeline moves unless the skid register is holding a result.
  assign adv           = !skid_valid_q;
  assign s_axis_tready = adv;
  assign s_fire        = s_axis_tvalid && adv;
  assign res_fire      = adv && s3_valid_q;
  assign m_fire        = out_valid_q && m_axis_tready;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_interval_q <= ScanIntervalRst;
    end else if (cfg_we_i) begin
      scan_interval_q <= cfg_wdata_i;
    end
  end

  // Unpack the incoming transfer.
  assign in_item.func   = func_e'(s_axis_tuser);
  assign in_item.digits = s_axis_tdata[31:0];
  assign in_item.mode   = s_axis_tdata[49:48];

  // Valid bits of the three pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s_fire;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Item payload travels alongside the decimal conversion.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q   <= in_item;
      s1_number_q <= s_axis_tdata[47:32];
      s2_item_q   <= s1_item_q;
      s3_item_q   <= s2_item_q;
    end
  end

  mlcd_bcd u_bcd (
    .clk_i    (clk_i),
    .en_i     (adv),
    .number_i (s1_number_q),
    .digits_o (bcd)
  );

  // Command decode and scan step for the item in the last stage.
  always_comb begin
    digit_d   = digit_q;
    tick_d    = tick_q;
    com_d     = com_q;
    first_d   = first_q;
    com_en_d  = com_en_q;
    com_lvl_d = com_lvl_q;
    seg_d     = seg_q;
    step      = 1'b0;
    cur       = (com_q > 2'd2) ? 2'd0 : com_q;
    row       = rows_q[cur];
    case (s3_item_q.func)
      FUNC_TICK: begin
        if ({1'b0, tick_q} + 9'd1 > {1'b0, scan_interval_q}) begin
          tick_d = '0;
          step   = 1'b1;
        end else begin
          tick_d = tick_q + 8'd1;
        end
      end
      FUNC_LOAD: begin
        digit_d = s3_item_q.digits;
      end
      FUNC_NUMBER: begin
        digit_d[0] = mlcd_font(bcd.d3);
        digit_d[1] = mlcd_font(bcd.d2);
        digit_d[2] = mlcd_font(bcd.d1);
        digit_d[3] = mlcd_font(bcd.d0);
      end
      FUNC_BATTERY: begin
        digit_d[2][7] = s3_item_q.mode[0];
        digit_d[1][7] = s3_item_q.mode[1];
      end
      FUNC_PLAY: begin
        if (s3_item_q.mode == IconOff) begin
          digit_d[0][7] = 1'b0;
        end else if (s3_item_q.mode == IconOn) begin
          digit_d[0][7] = 1'b1;
        end
      end
      FUNC_COLON: begin
        if (s3_item_q.mode == IconOff) begin
          digit_d[3][7] = 1'b0;
        end else if (s3_item_q.mode == IconOn) begin
          digit_d[3][7] = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        digit_d = '0;
      end
      default: begin
      end
    endcase
    // Half-slot scan: row bits with COM low, then inverted bits with COM high.
    if (step) begin
      com_en_d = ComW'(3'b001 << cur);
      if (first_q) begin
        seg_d     = row;
        com_lvl_d = 1'b0;
        first_d   = 1'b0;
        com_d     = cur;
      end else begin
        seg_d     = ~row;
        com_lvl_d = 1'b1;
        first_d   = 1'b1;
        com_d     = (cur == 2'd2) ? 2'd0 : cur + 2'd1;
      end
    end
  end

  assign result = {seg_d, com_lvl_d, com_en_d};

  // Display and scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q   <= '0;
      rows_q    <= '0;
      tick_q    <= '0;
      com_q     <= '0;
      first_q   <= 1'b1;
      com_en_q  <= '0;
      com_lvl_q <= 1'b0;
      seg_q     <= '1;
    end else if (res_fire) begin
      digit_q   <= digit_d;
      rows_q    <= mlcd_rows(digit_d);
      tick_q    <= tick_d;
      com_q     <= com_d;
      first_q   <= first_d;
      com_en_q  <= com_en_d;
      com_lvl_q <= com_lvl_d;
      seg_q     <= seg_d;
    end
  end

  // Output register and skid register valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (m_fire) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_fire;
      end
    end else if (res_fire) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk_i) begin
    if (m_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_fire) begin
        out_q <= result;
      end
    end else if (res_fire) begin
      if (!out_valid_q) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // At most one COM line is driven at any time.
  a_com_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(com_en_q))
    else $error("more than one COM line driven");

  // In the middle of a slot the driven COM is the one being scanned.
  a_com_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |-> (com_en_q == ComW'(3'b001 << com_q)))
    else $error("driven COM does not match scan position");

  // The COM index never reaches the unused code.
  a_com_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    com_q != 2'd3)
    else $error("COM index out of range");

  // The skid register only fills behind a stalled output register.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid register filled without a stall");

  // A held skid entry always has an occupied output register in front.
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register valid with empty output register");

endmodule

>>> bench/multiplexed_lcd_segment_driver_top_tb.sv
// Self-checking testbench for the multiplexed LCD segment driver: commands, scan timing and outputs.
module multiplexed_lcd_segment_driver_top_tb;
  import mlcd_pkg::*;

  // Command code that the block must ignore.
  localparam logic [FuncW-1:0] FuncUnused = 3'd7;

  // Battery icon modes.
  localparam logic [ModeW-1:0] BattOff    = 2'd0;
  localparam logic [ModeW-1:0] BattMiddle = 2'd1;
  localparam logic [ModeW-1:0] BattEnds   = 2'd2;
  localparam logic [ModeW-1:0] BattBoth   = 2'd3;

  // Icon modes that leave the play mark or the colon as they are.
  localparam logic [ModeW-1:0] IconKeepLo = 2'd2;
  localparam logic [ModeW-1:0] IconKeepHi = 2'd3;

  localparam int StallLimit = 1000;

  // Hex-capable seven-segment glyphs, bits a..g.
  localparam logic [DigitW-1:0] HexGlyph [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h67, 8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71
  };

  // Result layout from the top bit down: SEG levels, COM level, COM enables.
  typedef struct packed {
    logic [SegW-1:0] seg;
    logic            com_lvl;
    logic [ComW-1:0] com_en;
  } glass_drive_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgW-1:0]       cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic [FuncW-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OutDataW-1:0]   m_axis_tdata;

  // Shadow of the glass state and the scan register.
  logic [DigitW-1:0]     shadow_digits [NumDig];
  logic [SegW-1:0]       shadow_rows [3];
  logic [7:0]            shadow_ticks;
  logic [1:0]            shadow_com;
  logic                  shadow_first_half;
  glass_drive_t          shadow_drive;
  logic [CfgW-1:0]       shadow_interval;

  glass_drive_t          pending_drive [$];
  glass_drive_t          want_drive;
  glass_drive_t          got_drive;

  int                    mismatches = 0;
  int                    quiet_cycles = 0;
  int                    sink_burst = 0;
  bit                    sender_idle_en = 1'b0;
  bit                    sink_stall_en = 1'b0;

  multiplexed_lcd_segment_driver_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Rebuild the three COM row patterns from the digit bytes.
  task automatic remap_rows();
    logic [SegW-1:0] r0, r1, r2;
    r0 = '0;
    r1 = '0;
    r2 = '0;
    for (int i = 0; i < NumDig; i++) begin
      if (shadow_digits[i][0]) r0[3*i+1] = 1'b1;
      if (shadow_digits[i][1]) r0[3*i+2] = 1'b1;
      if (shadow_digits[i][2]) r1[3*i+2] = 1'b1;
      if (shadow_digits[i][3]) r2[3*i+1] = 1'b1;
      if (shadow_digits[i][4]) r1[3*i]   = 1'b1;
      if (shadow_digits[i][5]) r0[3*i]   = 1'b1;
      if (shadow_digits[i][6]) r1[3*i+1] = 1'b1;
    end
    // Icons sit on the third row: play, battery ends, battery middle, colon.
    if (shadow_digits[0][7]) r2[9] = 1'b1;
    if (shadow_digits[1][7]) r2[0] = 1'b1;
    if (shadow_digits[2][7]) r2[2] = 1'b1;
    if (shadow_digits[3][7]) r2[5] = 1'b1;
    shadow_rows[0] = r0;
    shadow_rows[1] = r1;
    shadow_rows[2] = r2;
  endtask

  // One half-slot of the COM scan.
  task automatic scan_half_slot();
    logic [1:0] c;
    c = (shadow_com > 2'd2) ? 2'd0 : shadow_com;
    shadow_drive.com_en = 3'b001 << c;
    if (shadow_first_half) begin
      shadow_drive.seg     = shadow_rows[c];
      shadow_drive.com_lvl = 1'b0;
      shadow_first_half    = 1'b0;
    end else begin
      shadow_drive.seg     = ~shadow_rows[c];
      shadow_drive.com_lvl = 1'b1;
      shadow_first_half    = 1'b1;
      c = (c == 2'd2) ? 2'd0 : c + 2'd1;
    end
    shadow_com = c;
  endtask

  // Play mark and colon: off, on, or left alone for the other modes.
  task automatic set_icon_bit(input int idx, input logic [ModeW-1:0] md);
    if (md == IconOff) shadow_digits[idx][7] = 1'b0;
    else if (md == IconOn) shadow_digits[idx][7] = 1'b1;
  endtask

  // Apply one command to the shadow state and queue the drive levels it leaves.
  task automatic predict_lcd_outputs(input logic [FuncW-1:0] f, input digits_t dig,
                                     input logic [NumW-1:0] num, input logic [ModeW-1:0] md);
    logic [8:0]  next_ticks;
    int unsigned v;
    case (f)
      FUNC_TICK: begin
        next_ticks = {1'b0, shadow_ticks} + 9'd1;
        if (next_ticks > {1'b0, shadow_interval}) begin
          shadow_ticks = '0;
          scan_half_slot();
        end else begin
          shadow_ticks = next_ticks[7:0];
        end
      end
      FUNC_LOAD: begin
        for (int i = 0; i < NumDig; i++) shadow_digits[i] = dig[i];
        remap_rows();
      end
      FUNC_NUMBER: begin
        v = num % 10000;
        shadow_digits[0] = HexGlyph[v / 1000];
        shadow_digits[1] = HexGlyph[(v % 1000) / 100];
        shadow_digits[2] = HexGlyph[(v % 100) / 10];
        shadow_digits[3] = HexGlyph[v % 10];
        remap_rows();
      end
      FUNC_BATTERY: begin
        shadow_digits[2][7] = md[0];
        shadow_digits[1][7] = md[1];
        remap_rows();
      end
      FUNC_PLAY: begin
        set_icon_bit(0, md);
        remap_rows();
      end
      FUNC_COLON: begin
        set_icon_bit(3, md);
        remap_rows();
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < NumDig; i++) shadow_digits[i] = '0;
        remap_rows();
      end
      default: ;
    endcase
    pending_drive.push_back(shadow_drive);
  endtask

  // Offer one command and wait for its transfer.
  task automatic send_command(input logic [FuncW-1:0] f, input digits_t dig,
                              input logic [NumW-1:0] num, input logic [ModeW-1:0] md);
    if (sender_idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {6'b0, md, num, dig};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_lcd_outputs(f, dig, num, md);
  endtask

  task automatic send_simple(input logic [FuncW-1:0] f, input logic [ModeW-1:0] md);
    send_command(f, '0, '0, md);
  endtask

  // Hold the sender until every queued result has come back.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_scan_interval(input logic [CfgW-1:0] value);
    wait_all_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_interval = value;
  endtask

  // Numbers around the modulo and decimal boundaries, or anywhere.
  function automatic logic [NumW-1:0] pick_number();
    case ($urandom_range(0, 4))
      0: pick_number = NumW'(16'hFFFF - $urandom_range(0, 9));
      1: pick_number = NumW'($urandom_range(9990, 10010));
      2: pick_number = NumW'($urandom_range(0, 9999));
      3: pick_number = NumW'($urandom_range(19990, 20010));
      default: pick_number = NumW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random_items(input int count, input int tick_pct);
    logic [FuncW-1:0] f;
    digits_t          dig;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < tick_pct) f = FUNC_TICK;
      else f = FuncW'($urandom_range(1, 7));
      for (int i = 0; i < NumDig; i++) dig[i] = DigitW'($urandom_range(0, 255));
      send_command(f, dig, pick_number(), ModeW'($urandom_range(0, 3)));
    end
  endtask

  // Every command at least once, number extremes and ignored icon modes, scanning on every tick.
  task automatic test_directed_commands();
    write_scan_interval(8'd0);
    send_command(FUNC_LOAD, {8'hFF, 8'hFF, 8'hFF, 8'hFF}, '0, BattOff);
    repeat (3) send_simple(FUNC_TICK, BattOff);
    send_command(FUNC_NUMBER, '0, 16'hFFFF, BattOff);
    send_command(FUNC_NUMBER, '0, 16'd9999, BattOff);
    send_command(FUNC_NUMBER, '0, 16'd10000, BattOff);
    send_command(FUNC_NUMBER, '0, 16'd0, BattOff);
    send_simple(FUNC_BATTERY, BattMiddle);
    send_simple(FUNC_BATTERY, BattEnds);
    send_simple(FUNC_BATTERY, BattBoth);
    send_simple(FUNC_TICK, BattOff);
    send_simple(FUNC_BATTERY, BattOff);
    send_simple(FUNC_PLAY, IconKeepLo);
    send_simple(FUNC_PLAY, IconOn);
    send_simple(FUNC_COLON, IconKeepHi);
    send_simple(FUNC_COLON, IconOn);
    send_simple(FUNC_TICK, BattOff);
    send_simple(FUNC_PLAY, IconOff);
    send_command(FuncUnused, {8'hA5, 8'h5A, 8'hFF, 8'hFF}, 16'hFFFF, BattBoth);
    send_simple(FUNC_CLEAR, BattOff);
    repeat (3) send_simple(FUNC_TICK, BattOff);
    send_command(FUNC_LOAD, {8'h01, 8'h80, 8'h55, 8'hAA}, '0, BattOff);
  endtask

  task automatic test_fastest_scan();
    write_scan_interval(8'd0);
    send_random_items(200, 50);
  endtask

  // The longest interval needs 256 ticks per step, so this phase is mostly ticks.
  task automatic test_largest_interval();
    write_scan_interval(8'd255);
    send_random_items(300, 95);
  endtask

  task automatic test_reset_interval();
    write_scan_interval(ScanIntervalRst);
    send_random_items(150, 60);
  endtask

  task automatic test_random_intervals();
    for (int p = 0; p < 3; p++) begin
      write_scan_interval(CfgW'($urandom_range(1, 12)));
      send_random_items(65, 60);
      wait_all_results();
      send_random_items(65, 60);
    end
  endtask

  task automatic test_back_to_back();
    sender_idle_en = 1'b0;
    sink_stall_en  = 1'b0;
    write_scan_interval(8'd2);
    send_random_items(180, 55);
  endtask

  // Result sink with random stall bursts.
  always @(posedge clk_i) begin
    if (sink_burst > 0) begin
      m_axis_tready <= 1'b0;
      sink_burst    <= sink_burst - 1;
    end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      sink_burst    <= $urandom_range(0, 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest prediction and watch for a stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("multiplexed_lcd_segment_driver_top: mismatch");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_drive = m_axis_tdata;
        if (pending_drive.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: en %b lvl %b seg %h",
                     got_drive.com_en, got_drive.com_lvl, got_drive.seg);
        end else begin
          want_drive = pending_drive.pop_front();
          if (got_drive.com_en !== want_drive.com_en || got_drive.com_lvl !== want_drive.com_lvl ||
              got_drive.seg !== want_drive.seg) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result error: expected en %b lvl %b seg %h, got en %b lvl %b seg %h",
                       want_drive.com_en, want_drive.com_lvl, want_drive.seg,
                       got_drive.com_en, got_drive.com_lvl, got_drive.seg);
          end
        end
      end
    end
  end

  initial begin
    // Shadow state after reset.
    for (int i = 0; i < NumDig; i++) shadow_digits[i] = '0;
    for (int i = 0; i < 3; i++) shadow_rows[i] = '0;
    shadow_ticks      = '0;
    shadow_com        = '0;
    shadow_first_half = 1'b1;
    shadow_drive      = '{com_en: '0, com_lvl: 1'b0, seg: '1};
    shadow_interval   = ScanIntervalRst;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_commands();
    sender_idle_en = 1'b1;
    sink_stall_en  = 1'b1;
    test_fastest_scan();
    test_largest_interval();
    test_reset_interval();
    test_random_intervals();
    test_back_to_back();

    wait_all_results();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("multiplexed_lcd_segment_driver_top: match");
    end else begin
      $display("multiplexed_lcd_segment_driver_top: mismatch");
    end
    $finish;
  end

endmodule
